// ----- rtl/core/zero_empty_slot_table_unit_macros.svh -----
// assertion helpers for the slot table unit
`ifndef ZERO_EMPTY_SLOT_TABLE_UNIT_MACROS_SVH
`define ZERO_EMPTY_SLOT_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, quiet while in reset
`define ZESTU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, checked on clk, quiet while in reset
`define ZESTU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- rtl/core/zestu_pkg.sv -----
`default_nettype none
package zestu_pkg;

	// table geometry
	localparam int CAPACITY = 16;
	localparam int POS_W = $clog2(CAPACITY);
	localparam int SIZE_W = 5;
	localparam int REQ_W = 3;
	localparam int IDX_W = 8;
	localparam int VAL_W = 32;
	localparam int STAT_W = 3;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
	localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAPACITY);

	// request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_EXCLUDE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PUSH = 3'd2;
	localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_SUCCESS = 3'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
	localparam logic [STAT_W-1:0] ST_OCCUPIED = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL = 3'd4;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/zestu_ctrl.sv -----
`default_nettype none
module zestu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output zestu_pkg::dp_cmd_t       cmd
);

	zestu_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	// state and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zestu_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q;
		cmd = '0;
		in_stall = 1'b1;
		// an output beat taken frees the result register
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			zestu_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = zestu_pkg::S_EXEC;
				end
			end
			zestu_pkg::S_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					cmd.exec = 1'b1;
					out_valid_d = 1'b1;
					state_d = zestu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = zestu_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/zestu_dp.sv -----
`default_nettype none
module zestu_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire zestu_pkg::dp_cmd_t                  cmd,
	input  wire logic                                cfg_we,
	input  wire logic [zestu_pkg::SIZE_W-1:0]        cfg_wdata,
	input  wire logic [zestu_pkg::REQ_W-1:0]         req_type,
	input  wire logic signed [zestu_pkg::IDX_W-1:0]  slot_index,
	input  wire logic signed [zestu_pkg::VAL_W-1:0]  value,
	output logic [zestu_pkg::STAT_W-1:0]             status
);

	// request latched at the input beat; only whether the word is nonzero matters
	logic [zestu_pkg::REQ_W-1:0] req_q;
	logic [zestu_pkg::IDX_W-1:0] idx_q;
	logic nz_q;
	logic [zestu_pkg::STAT_W-1:0] status_q;

	// occupancy bit per slot (slot holds a nonzero word) and active size
	logic [zestu_pkg::CAPACITY-1:0] occ_q, occ_d;
	logic [zestu_pkg::SIZE_W-1:0] size_q;

	logic [zestu_pkg::SIZE_W-1:0] eff;
	logic [zestu_pkg::CAPACITY-1:0] in_range, free;
	logic idx_ok, found;
	logic [zestu_pkg::POS_W-1:0] pos, fpos;
	logic [zestu_pkg::STAT_W-1:0] st_d;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			idx_q <= slot_index;
			nz_q <= |value;
		end
		if (cmd.exec) begin
			status_q <= st_d;
		end
	end

	// table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			size_q <= zestu_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			occ_q <= '0;
			size_q <= cfg_wdata;
		end else if (cmd.exec) begin
			occ_q <= occ_d;
		end
	end

	// effective size, slot range mask and index check
	always_comb begin
		eff = (size_q > zestu_pkg::SIZE_CAP) ? zestu_pkg::SIZE_CAP : size_q;
		for (int i = 0; i < zestu_pkg::CAPACITY; i++) begin
			in_range[i] = (i < int'(eff));
		end
		idx_ok = !idx_q[zestu_pkg::IDX_W-1]
			&& ({1'b0, idx_q[zestu_pkg::IDX_W-2:0]} < zestu_pkg::IDX_W'(eff));
		pos = zestu_pkg::POS_W'(idx_q[zestu_pkg::IDX_W-2:0]);
	end

	// priority encoder for the lowest free slot
	always_comb begin
		free = ~occ_q & in_range;
		found = 1'b0;
		fpos = '0;
		for (int i = zestu_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (free[i]) begin
				found = 1'b1;
				fpos = zestu_pkg::POS_W'(i);
			end
		end
	end

	// request execution
	always_comb begin
		occ_d = occ_q;
		st_d = zestu_pkg::ST_INVALID;
		case (req_q)
			zestu_pkg::REQ_INSERT: begin
				if (idx_ok) begin
					if (occ_q[pos]) begin
						st_d = zestu_pkg::ST_OCCUPIED;
					end else begin
						occ_d[pos] = nz_q;
						st_d = zestu_pkg::ST_SUCCESS;
					end
				end
			end
			zestu_pkg::REQ_EXCLUDE: begin
				if (idx_ok) begin
					if (!occ_q[pos]) begin
						st_d = zestu_pkg::ST_EMPTY;
					end else begin
						occ_d[pos] = 1'b0;
						st_d = zestu_pkg::ST_SUCCESS;
					end
				end
			end
			zestu_pkg::REQ_PUSH: begin
				if (found) begin
					occ_d[fpos] = nz_q;
					st_d = zestu_pkg::ST_SUCCESS;
				end else begin
					st_d = zestu_pkg::ST_FULL;
				end
			end
			zestu_pkg::REQ_UPDATE: begin
				if (idx_ok) begin
					occ_d[pos] = nz_q;
					st_d = zestu_pkg::ST_SUCCESS;
				end
			end
			zestu_pkg::REQ_CLEAR: begin
				occ_d = '0;
				st_d = zestu_pkg::ST_SUCCESS;
			end
			default: begin
				st_d = zestu_pkg::ST_INVALID;
			end
		endcase
	end

	assign status = status_q;

endmodule
`default_nettype wire

// ----- rtl/core/zero_empty_slot_table_unit.sv -----
// Slot table of 16 signed 32-bit words where zero marks an empty slot; each
// request beat (insert, exclude, push, update, clear all) returns one status
// beat. A request is captured in the idle state; the execute state then runs the
// occupancy check, the lowest-free-slot priority encoder and the update, so
// the block takes no new request before the last one has run. The status sits in
// an output register, so the next request is taken while it waits. A write
// of cfg_wdata sets the active size and empties the table in the same cycle;
// write it only while no request is in flight.
`default_nettype none
`include "zero_empty_slot_table_unit_macros.svh"
module zero_empty_slot_table_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [zestu_pkg::SIZE_W-1:0]        cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [zestu_pkg::REQ_W-1:0]         req_type,
	input  wire logic signed [zestu_pkg::IDX_W-1:0]  slot_index,
	input  wire logic signed [zestu_pkg::VAL_W-1:0]  value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [zestu_pkg::STAT_W-1:0]             status
);

	zestu_pkg::dp_cmd_t cmd;

	// sequencer
	zestu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// occupancy table and status logic
	zestu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.slot_index (slot_index),
		.value      (value),
		.status     (status)
	);

	// checks
	`ZESTU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request accepted while busy")
	`ZESTU_ASSERT_NEXT(a_no_early_status, in_valid && !in_stall && !out_valid, !out_valid, "status before execute")
	`ZESTU_ASSERT_NOW(a_status_code, out_valid, status <= zestu_pkg::ST_FULL, "status code out of range")

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;
	import zestu_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 4;

	// request codes the block does not define
	localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_CLEAR + 1'b1;
	localparam logic [REQ_W-1:0] REQ_SPARE_LAST = '1;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [IDX_W-1:0] IDX_MAX = 8'sh7F;
	localparam logic signed [IDX_W-1:0] IDX_MIN = 8'sh80;

	typedef enum int {
		RX_FLOW,
		RX_COIN,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [REQ_W-1:0] req_type;
	logic signed [IDX_W-1:0] slot_index;
	logic signed [VAL_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [STAT_W-1:0] status;

	// shadow of the table and its size
	logic [VAL_W-1:0] slot_words [CAPACITY];
	logic [SIZE_W-1:0] table_size;

	logic [STAT_W-1:0] pending_status [$];
	int fail_count = 0;
	int burst_left = 0;
	int hold_requests = 0;

	zero_empty_slot_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.slot_index(slot_index),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void clear_slots();
		foreach (slot_words[i]) slot_words[i] = '0;
	endfunction

	// status of one request, applied to the shadow table
	function automatic logic [STAT_W-1:0] predict_status(input logic [REQ_W-1:0] r,
			input logic signed [IDX_W-1:0] idx, input logic [VAL_W-1:0] v);
		int unsigned top;
		int unsigned pos;
		logic hit;
		logic [STAT_W-1:0] st;
		top = (table_size > CAPACITY) ? CAPACITY : table_size;
		pos = idx[IDX_W-2:0];
		hit = !idx[IDX_W-1] && (pos < top);
		st = ST_INVALID;
		case (r)
			REQ_INSERT: begin
				if (hit) begin
					if (slot_words[pos] != '0) begin
						st = ST_OCCUPIED;
					end else begin
						slot_words[pos] = v;
						st = ST_SUCCESS;
					end
				end
			end
			REQ_EXCLUDE: begin
				if (hit) begin
					if (slot_words[pos] == '0) begin
						st = ST_EMPTY;
					end else begin
						slot_words[pos] = '0;
						st = ST_SUCCESS;
					end
				end
			end
			REQ_PUSH: begin
				st = ST_FULL;
				for (int i = 0; i < top; i++) begin
					if (slot_words[i] == '0) begin
						slot_words[i] = v;
						st = ST_SUCCESS;
						break;
					end
				end
			end
			REQ_UPDATE: begin
				if (hit) begin
					slot_words[pos] = v;
					st = ST_SUCCESS;
				end
			end
			REQ_CLEAR: begin
				clear_slots();
				st = ST_SUCCESS;
			end
			default: st = ST_INVALID;
		endcase
		return st;
	endfunction

	// one request beat, with a random gap at each burst boundary
	task automatic send_req(input logic [REQ_W-1:0] r, input logic signed [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= r;
		slot_index <= idx;
		value <= v;
		do @(posedge clk); while (in_stall);
		pending_status.push_back(predict_status(r, idx, v));
	endtask

	// random request, weighted toward well-formed traffic on the active slots
	task automatic send_random_req();
		int pick;
		int top;
		logic [REQ_W-1:0] r;
		logic signed [IDX_W-1:0] idx;
		logic signed [VAL_W-1:0] v;
		top = (table_size > CAPACITY) ? CAPACITY : table_size;
		pick = $urandom_range(0, 99);
		if (pick < 26) r = REQ_INSERT;
		else if (pick < 46) r = REQ_EXCLUDE;
		else if (pick < 70) r = REQ_PUSH;
		else if (pick < 86) r = REQ_UPDATE;
		else if (pick < 90) r = REQ_CLEAR;
		else r = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
		if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom_range(0, 255));
		else idx = IDX_W'($urandom_range(0, top));
		case ($urandom_range(0, 19))
			0, 1: v = '0;
			2: v = VAL_MIN;
			3: v = VAL_MAX;
			4: v = '1;
			default: v = $urandom;
		endcase
		send_req(r, idx, v);
	endtask

	// stop offering and wait for every outstanding status
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// size write, only with the block idle; it also empties the table
	task automatic write_size(input logic [SIZE_W-1:0] sz);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we <= 1'b0;
		table_size = sz;
		clear_slots();
	endtask

	task automatic test_request_codes();
		send_req(REQ_EXCLUDE, 0, 1);
		send_req(REQ_INSERT, 0, VAL_MAX);
		send_req(REQ_INSERT, 0, 5);
		send_req(REQ_INSERT, 15, VAL_MIN);
		send_req(REQ_INSERT, 16, 7);
		send_req(REQ_INSERT, -1, 7);
		send_req(REQ_UPDATE, IDX_MAX, 7);
		send_req(REQ_EXCLUDE, IDX_MIN, 7);
		send_req(REQ_EXCLUDE, 0, 0);
		send_req(REQ_EXCLUDE, 0, 0);
		// storing zero leaves the slot empty
		send_req(REQ_PUSH, 8'sh55, 0);
		send_req(REQ_PUSH, 0, -1);
		send_req(REQ_INSERT, 3, 0);
		send_req(REQ_EXCLUDE, 3, 0);
		send_req(REQ_UPDATE, 15, 32'sh5555_AAAA);
		send_req(REQ_UPDATE, 15, 0);
		send_req(REQ_EXCLUDE, 15, 0);
		send_req(REQ_SPARE_FIRST, 0, 3);
		send_req(REQ_SPARE_FIRST + 1'b1, 0, 3);
		send_req(REQ_SPARE_LAST, 0, 3);
		send_req(REQ_CLEAR, -1, VAL_MAX);
		send_req(REQ_EXCLUDE, 0, 0);
	endtask

	task automatic test_size_limits();
		write_size(1);
		send_req(REQ_PUSH, 0, 11);
		send_req(REQ_PUSH, 0, 12);
		send_req(REQ_INSERT, 1, 13);
		send_req(REQ_EXCLUDE, 0, 0);
		// zero size: nothing addressable, push always full
		write_size(0);
		send_req(REQ_INSERT, 0, 1);
		send_req(REQ_PUSH, 0, 1);
		send_req(REQ_CLEAR, 0, 0);
		write_size(3);
		repeat (4) send_req(REQ_PUSH, 0, $urandom | 1);
		// size above capacity saturates
		write_size(31);
		send_req(REQ_UPDATE, 15, VAL_MIN);
		send_req(REQ_UPDATE, 16, VAL_MIN);
		// size write empties the table
		write_size(SIZE_RESET);
		send_req(REQ_EXCLUDE, 15, 0);
	endtask

	task automatic test_backpressure();
		hold_requests <= hold_requests + 1;
		repeat (40) send_random_req();
		drain();
	endtask

	task automatic test_random_traffic();
		logic [SIZE_W-1:0] sizes [7];
		int counts [7];
		sizes = '{SIZE_RESET, 5'd4, 5'd1, 5'd31, 5'd0, SIZE_W'($urandom_range(2, 15)),
			SIZE_RESET};
		counts = '{90, 80, 50, 80, 20, 90, 114};
		foreach (sizes[p]) begin
			write_size(sizes[p]);
			repeat (counts[p]) send_random_req();
		end
	endtask

	// status checker
	always @(posedge clk) begin
		logic [STAT_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				$error("status: no beat expected, actual %0d", status);
				fail_count++;
			end else begin
				want = pending_status.pop_front();
				if (status !== want) begin
					$error("status: expected %0d, actual %0d", want, status);
					fail_count++;
				end
			end
		end
	end

	// receiver stall patterns, plus the long hold on request
	int holds_done = 0;
	int hold_left = 0;
	int mode_left = 0;
	int rx_cycle = 0;
	rx_mode_e rx_mode = RX_FLOW;
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_requests != holds_done) begin
			holds_done++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_FLOW: out_stall <= 1'b0;
				RX_COIN: out_stall <= $urandom_range(0, 1);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (rx_cycle % 3 == 0);
			endcase
		end
	end

	// watchdog on cycles without any accepted beat
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = '0;
		slot_index = '0;
		value = '0;
		out_stall = 1'b0;
		table_size = SIZE_RESET;
		clear_slots();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_request_codes();
		test_size_limits();
		test_backpressure();
		test_random_traffic();
		drain();
		if (fail_count == 0 && pending_status.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
